/* design/rcpn_pkg.sv */
package rcpn_pkg;

    // Field and register widths
    localparam int CAL_W     = 16;
    localparam int NORM_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Quotient bits: magnitude stays below full scale (2^15)
    localparam int QUOT_W = 15;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH   = 2'd2;

    // Reset values of the calibration points
    localparam logic [CAL_W-1:0] CAL_LOW_RESET    = 16'd1050;
    localparam logic [CAL_W-1:0] CAL_CENTER_RESET = 16'd1520;
    localparam logic [CAL_W-1:0] CAL_HIGH_RESET   = 16'd1950;

    // Output limits
    localparam logic [NORM_W-1:0] NORM_MIN = 16'h8000;
    localparam logic [NORM_W-1:0] NORM_MAX = 16'h7FFF;

    // Which segment of the curve a sample falls in
    typedef enum logic [1:0] {
        MODE_SAT_LOW,
        MODE_SAT_HIGH,
        MODE_UPPER,
        MODE_LOWER
    } mode_t;

endpackage

/* design/rc_pulse_to_normalized_value_top.sv */
// Three-point calibration of an RC pulse width into a signed stick position.
// One beat is accepted on every cycle that start is high; busy stays low, so
// samples may follow back to back with no gap. Each result appears on
// norm_value with done high for exactly one cycle, in the order the
// samples came in; the receiver cannot stall. The pipeline is one input
// stage that picks the segment and forms the dividend and divisor, a
// 15-stage restoring divider that resolves one quotient bit per stage,
// and one output stage that applies sign and limits.
// Calibration points are written through cfg_write/cfg_index/cfg_data and
// must only change while no sample is in flight.
module rc_pulse_to_normalized_value_top #(
    parameter int RAW_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rcpn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcpn_pkg::CAL_W-1:0]     cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [rcpn_pkg::CAL_W-1:0]     pulse_width,
    output logic                          done,
    output logic signed [rcpn_pkg::NORM_W-1:0] norm_value
);
    import rcpn_pkg::*;

    localparam int EXT_W = RAW_WIDTH + CAL_W;

    // Calibration registers
    logic [CAL_W-1:0] cal_low_reg;
    logic [CAL_W-1:0] cal_center_reg;
    logic [CAL_W-1:0] cal_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg    <= CAL_LOW_RESET;
            cal_center_reg <= CAL_CENTER_RESET;
            cal_high_reg   <= CAL_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CAL_LOW:    cal_low_reg    <= cfg_data;
                REG_CAL_CENTER: cal_center_reg <= cfg_data;
                REG_CAL_HIGH:   cal_high_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // No back-pressure: a beat is taken every cycle
    assign busy = 1'b0;

    // Values reduced modulo 2^RAW_WIDTH
    logic [EXT_W-1:0]     raw_ext;
    logic [EXT_W-1:0]     lo_ext;
    logic [EXT_W-1:0]     mid_ext;
    logic [EXT_W-1:0]     hi_ext;
    logic [RAW_WIDTH-1:0] raw;
    logic [RAW_WIDTH-1:0] lo;
    logic [RAW_WIDTH-1:0] mid;
    logic [RAW_WIDTH-1:0] hi;

    assign raw_ext = EXT_W'(pulse_width);
    assign lo_ext  = EXT_W'(cal_low_reg);
    assign mid_ext = EXT_W'(cal_center_reg);
    assign hi_ext  = EXT_W'(cal_high_reg);
    assign raw     = raw_ext[RAW_WIDTH-1:0];
    assign lo      = lo_ext[RAW_WIDTH-1:0];
    assign mid     = mid_ext[RAW_WIDTH-1:0];
    assign hi      = hi_ext[RAW_WIDTH-1:0];

    // Pipeline stage arrays: index 0 is the input stage, index QUOT_W the divider end
    logic                 valid_reg [0:QUOT_W];
    mode_t                mode_reg  [0:QUOT_W];
    logic [RAW_WIDTH-1:0] rem_reg   [0:QUOT_W];
    logic [RAW_WIDTH-1:0] den_reg   [0:QUOT_W];
    logic [QUOT_W-1:0]    quot_reg  [0:QUOT_W];

    // Input stage: segment select, numerator (below divisor) and divisor
    mode_t                mode_next;
    logic [RAW_WIDTH-1:0] num_next;
    logic [RAW_WIDTH-1:0] den_next;

    always_comb
    begin
        num_next = raw - mid;
        den_next = hi - mid;
        if (raw <= lo)
        begin
            mode_next = MODE_SAT_LOW;
        end
        else if (raw >= hi)
        begin
            mode_next = MODE_SAT_HIGH;
        end
        else if (raw >= mid)
        begin
            mode_next = MODE_UPPER;
        end
        else
        begin
            mode_next = MODE_LOWER;
            num_next  = mid - raw;
            den_next  = mid - lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg[0] <= mode_next;
        rem_reg[0]  <= num_next;
        den_reg[0]  <= den_next;
        quot_reg[0] <= '0;
    end

    // Restoring divider: one quotient bit per stage, remainder stays below divisor
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        logic [RAW_WIDTH:0]   dbl;
        logic [RAW_WIDTH:0]   diff;
        logic                 qbit;
        logic [RAW_WIDTH-1:0] rem_next;

        always_comb
        begin
            dbl      = {rem_reg[k], 1'b0};
            diff     = dbl - {1'b0, den_reg[k]};
            qbit     = (dbl >= {1'b0, den_reg[k]});
            rem_next = qbit ? diff[RAW_WIDTH-1:0] : dbl[RAW_WIDTH-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            mode_reg[k+1] <= mode_reg[k];
            rem_reg[k+1]  <= rem_next;
            den_reg[k+1]  <= den_reg[k];
            quot_reg[k+1] <= {quot_reg[k][QUOT_W-2:0], qbit};
        end
    end

    // Output stage: sign and limits
    logic [NORM_W-1:0] norm_next;
    logic [NORM_W-1:0] norm_reg;
    logic              done_reg;

    always_comb
    begin
        case (mode_reg[QUOT_W])
            MODE_SAT_LOW:  norm_next = NORM_MIN;
            MODE_SAT_HIGH: norm_next = NORM_MAX;
            MODE_UPPER:    norm_next = {1'b0, quot_reg[QUOT_W]};
            MODE_LOWER:    norm_next = NORM_W'(0) - {1'b0, quot_reg[QUOT_W]};
            default:       norm_next = NORM_MIN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
    end

    assign done       = done_reg;
    assign norm_value = $signed(norm_reg);

endmodule
